### rtl/ils_pkg.sv
// ils_pkg: shared constants, command and status codes, and word types of the
// indexed list store. Depends on nothing; imported by rtl/indexed_list_store.sv.
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int AddrW    = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int PosW     = 7;
  localparam int ValW     = 32;

  typedef enum logic [2:0] {
    CMD_READ = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                   command;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    status_e                status;
  } out_word_t;

  localparam logic signed [ValW-1:0] NoValue = '1;

endpackage

### rtl/indexed_list_store.sv
// indexed_list_store: ordered list of signed 32-bit values in one element RAM,
// with a small sequencer that moves one element per cycle. Depends on ils_pkg.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i, in_stall_o | in_data_i (command, position, value)
//   out     | output    | out_valid_o, out_stall_i | out_data_o (read_value, status)
//
// A refused or unused command, an append and a delete of the last element are answered straight
// from IDLE; a read passes through READ. An insert in the middle moves count - position elements,
// one per cycle, through SHIFT, DRAIN and FILL; a delete in the middle moves count - position - 1
// through SHIFT and DRAIN. Reset clears the state, the element count, the pending move and the
// output valid flag; the element RAM and the data registers are not reset.
// A new word is taken only while the sequencer is idle and the output register is empty.
module indexed_list_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ils_pkg::in_word_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ils_pkg::out_word_t out_data_o
);
  import ils_pkg::*;

  localparam int CmpW = (CntW > PosW) ? CntW : PosW;

  // Sequencer states. SHIFT reads one element per cycle while the element
  // read in the previous cycle is written one slot over. DRAIN retires the
  // last pending move, FILL writes the new value into the opened slot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FILL  = 5'b01000,
    S_READ  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [AddrW-1:0]       src_q, src_d;
  logic [AddrW-1:0]       last_q, last_d;
  logic [AddrW-1:0]       pos_q, pos_d;
  logic                   is_ins_q, is_ins_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic                   wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]       wr_addr_q, wr_addr_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;

  // Element RAM: one write port, one read port with registered data.
  logic signed [ValW-1:0] mem [CAPACITY];
  logic signed [ValW-1:0] rdata_q;
  logic                   we_c;
  logic [AddrW-1:0]       waddr_c;
  logic signed [ValW-1:0] wdata_c;
  logic [AddrW-1:0]       raddr_c;

  logic                   accept_c;
  logic [CmpW-1:0]        pos_ext_c;
  logic [CmpW-1:0]        cnt_ext_c;
  logic [CmpW-1:0]        ins_p_c;

  assign accept_c    = in_valid_i && !in_stall_o;
  assign in_stall_o  = !((state_q == S_IDLE) && !out_valid_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pos_ext_c = CmpW'(in_data_i.position);
  assign cnt_ext_c = CmpW'(cnt_q);

  always_comb begin
    unique case (in_data_i.command)
      CMD_HEAD: ins_p_c = '0;
      CMD_TAIL: ins_p_c = cnt_ext_c;
      default:  ins_p_c = pos_ext_c;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    last_d      = last_q;
    pos_d       = pos_q;
    is_ins_d    = is_ins_q;
    val_d       = val_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    raddr_c     = src_q;
    we_c        = wr_pend_q;
    waddr_c     = wr_addr_q;
    wdata_c     = rdata_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept_c) begin
          out_d.read_value = NoValue;
          out_d.status     = ST_DONE;
          unique case (in_data_i.command)
            CMD_READ: begin
              if (pos_ext_c < cnt_ext_c) begin
                raddr_c = AddrW'(in_data_i.position);
                state_d = S_READ;
              end else begin
                out_d.status = ST_RANGE;
                out_valid_d  = 1'b1;
              end
            end
            CMD_HEAD, CMD_TAIL, CMD_AT: begin
              out_valid_d = 1'b1;
              if (ins_p_c > cnt_ext_c) begin
                out_d.status = ST_RANGE;
              end else if (cnt_q == CntW'(CAPACITY)) begin
                out_d.status = ST_FULL;
              end else if (ins_p_c == cnt_ext_c) begin
                // Append: nothing to move, the value goes straight in.
                we_c    = 1'b1;
                waddr_c = AddrW'(ins_p_c);
                wdata_c = in_data_i.value;
                cnt_d   = cnt_q + CntW'(1);
              end else begin
                out_valid_d = 1'b0;
                src_d       = AddrW'(cnt_q - CntW'(1));
                last_d      = AddrW'(ins_p_c);
                pos_d       = AddrW'(ins_p_c);
                val_d       = in_data_i.value;
                is_ins_d    = 1'b1;
                state_d     = S_SHIFT;
              end
            end
            CMD_DEL: begin
              out_valid_d = 1'b1;
              if (pos_ext_c >= cnt_ext_c) begin
                out_d.status = ST_RANGE;
              end else if (pos_ext_c == cnt_ext_c - CmpW'(1)) begin
                cnt_d = cnt_q - CntW'(1);
              end else begin
                out_valid_d = 1'b0;
                src_d       = AddrW'(in_data_i.position) + AddrW'(1);
                last_d      = AddrW'(cnt_q - CntW'(1));
                is_ins_d    = 1'b0;
                state_d     = S_SHIFT;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        raddr_c   = src_q;
        wr_pend_d = 1'b1;
        wr_addr_d = is_ins_q ? src_q + AddrW'(1) : src_q - AddrW'(1);
        if (src_q == last_q) begin
          state_d = S_DRAIN;
        end else begin
          src_d = is_ins_q ? src_q - AddrW'(1) : src_q + AddrW'(1);
        end
      end
      S_DRAIN: begin
        if (is_ins_q) begin
          state_d = S_FILL;
        end else begin
          cnt_d            = cnt_q - CntW'(1);
          out_d.read_value = NoValue;
          out_d.status     = ST_DONE;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FILL: begin
        we_c             = 1'b1;
        waddr_c          = pos_q;
        wdata_c          = val_q;
        cnt_d            = cnt_q + CntW'(1);
        out_d.read_value = NoValue;
        out_d.status     = ST_DONE;
        out_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
      S_READ: begin
        out_d.read_value = rdata_q;
        out_d.status     = ST_DONE;
        out_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rdata_q <= mem[raddr_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q     <= src_d;
    last_q    <= last_d;
    pos_q     <= pos_d;
    is_ins_q  <= is_ins_d;
    val_q     <= val_d;
    wr_addr_q <= wr_addr_d;
    out_q     <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CntW'(1) || cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("element count moved by more than one");

  a_pend_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_SHIFT || state_q == S_DRAIN))
    else $error("pending move outside a shift");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> state_q == S_IDLE)
    else $error("result raised while the sequencer is busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_FULL) |-> cnt_q == CntW'(CAPACITY))
    else $error("full status with room left");
`endif

endmodule
